>>> sv/ppghr_pkg.sv
// shared types and constants for the ppg heart rate detector
// used by ppg_heart_rate_detector_unit; no dependencies
package ppghr_pkg;

	// sample and fixed-point layout
	localparam int SAMPLE_BITS = 18;
	localparam int FRAC_W      = 16;                   // fraction bits of the averages
	localparam int AVG_W       = SAMPLE_BITS + FRAC_W; // unsigned Q18.16 average
	localparam int ALU_W       = AVG_W + 3;            // signed width of the shared adder
	localparam int AC_W        = SAMPLE_BITS + 1;      // signed ac value
	localparam int BIT_W       = $clog2(FRAC_W);       // multiply step counter

	// beat timing
	localparam int CNT_W          = 32;
	localparam int INTERVAL_SLOTS = 8;
	localparam int IV_W           = 10;
	localparam int PTR_W          = $clog2(INTERVAL_SLOTS);
	localparam int STORED_W       = $clog2(INTERVAL_SLOTS + 1);
	localparam int SUM_W          = $clog2(INTERVAL_SLOTS * (1 << IV_W));
	localparam int REM_W          = SUM_W + 1;

	// bpm scaling: 60 * rate * 256 * count
	localparam int RATE_W      = 9;
	localparam int SECONDS_MIN = 60;
	localparam int BPM_FRAC    = 8;
	localparam int BPM_W       = 16;
	localparam int RC_W        = $clog2(SECONDS_MIN * ((1 << RATE_W) - 1) * INTERVAL_SLOTS + 1);
	localparam int NUM_W       = RC_W + BPM_FRAC;
	localparam int DIV_CNT_W   = $clog2(NUM_W);

	// detection constants
	localparam int AC_MAG_MIN   = 50;
	localparam int PEAK_MIN     = 100;
	localparam int MIN_INTERVALS = 2;

	// configuration port
	localparam int THR_W      = 18;
	localparam int ALPHA_W    = 16;
	localparam int MIN_IV_W   = 7;
	localparam int CFG_DATA_W = 18;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IR_THRESHOLD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DC_ALPHA     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL = 3'd4;

	localparam logic [RATE_W-1:0]   RESET_SAMPLE_RATE = 9'd100;
	localparam logic [THR_W-1:0]    RESET_IR_THR      = 18'd8000;
	localparam logic [ALPHA_W-1:0]  RESET_DC_ALPHA    = 16'd819;
	localparam logic [MIN_IV_W-1:0] RESET_MIN_IV      = 7'd30;
	localparam logic [IV_W-1:0]     RESET_MAX_IV      = 10'd200;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIFF,
		ST_MUL,
		ST_SLOW,
		ST_FAST1,
		ST_FAST2,
		ST_AC,
		ST_DETECT,
		ST_NUM,
		ST_SUM,
		ST_DIV,
		ST_SAT,
		ST_DONE
	} state_t;

endpackage

>>> sv/ppg_heart_rate_detector_unit.sv
// ppg heart rate detector: one ir sample in, one result out per transfer
// steps: load, diff, multiply, slow and fast averages, ac, detect; on a beat with
//   two or more intervals also ring sum and, if nonzero, bpm divide and saturate
// a new sample is accepted only in idle, after the last result is registered; the
//   add/subtract steps share one 37-bit unit (16 multiply steps, 26 divide steps)
// reset (arst_n low): averages, history, counters and bpm clear, registers
//   take their default values; the interval ring holds no defined contents
// depends on ppghr_pkg
module ppg_heart_rate_detector_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// sample input
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [ppghr_pkg::SAMPLE_BITS-1:0]     ir_sample,
	// result output
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [ppghr_pkg::AC_W-1:0]     ac_value,
	output logic                                  finger_present,
	output logic                                  beat_found,
	output logic [ppghr_pkg::BPM_W-1:0]           bpm,
	// configuration writes
	input  logic                                  cfg_we,
	input  logic [ppghr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ppghr_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int ALU_W = ppghr_pkg::ALU_W;
	localparam int AVG_W = ppghr_pkg::AVG_W;
	localparam int FRAC_W = ppghr_pkg::FRAC_W;
	localparam int AC_W = ppghr_pkg::AC_W;
	localparam int CNT_W = ppghr_pkg::CNT_W;
	localparam int IV_W = ppghr_pkg::IV_W;
	localparam int SUM_W = ppghr_pkg::SUM_W;
	localparam int REM_W = ppghr_pkg::REM_W;
	localparam int NUM_W = ppghr_pkg::NUM_W;
	localparam int RC_W = ppghr_pkg::RC_W;
	localparam int PTR_W = ppghr_pkg::PTR_W;
	localparam int STORED_W = ppghr_pkg::STORED_W;
	localparam int SLOTS = ppghr_pkg::INTERVAL_SLOTS;
	localparam int BPM_W = ppghr_pkg::BPM_W;

	// ---------------- configuration registers ----------------
	logic [ppghr_pkg::RATE_W-1:0]   rate_q;
	logic [ppghr_pkg::THR_W-1:0]    thr_q;
	logic [ppghr_pkg::ALPHA_W-1:0]  alpha_q;
	logic [ppghr_pkg::MIN_IV_W-1:0] min_iv_q;
	logic [IV_W-1:0]                max_iv_q;

	// ---------------- sequencer ----------------
	ppghr_pkg::state_t state_q, state_d;

	// ---------------- persistent detector state ----------------
	logic [AVG_W-1:0]          slow_q;      // slow (dc) average
	logic [AVG_W-1:0]          fast_q;      // fast average, weight 1/4
	logic signed [AC_W-1:0]    hist_old_q;  // older of the two kept history entries
	logic signed [AC_W-1:0]    hist_mid_q;  // newest history entry, middle after next shift
	logic [CNT_W-1:0]          cnt_q;       // samples seen before the current one
	logic [CNT_W-1:0]          last_peak_q;
	logic                      peak_seen_q;
	logic [IV_W-1:0]           ring_q [SLOTS];
	logic [PTR_W-1:0]          ptr_q;
	logic [STORED_W-1:0]       stored_q;
	logic [BPM_W-1:0]          bpm_q;

	// ---------------- per-sample working registers ----------------
	logic [ppghr_pkg::SAMPLE_BITS-1:0] sample_q;
	logic signed [ALU_W-1:0]   d_q;         // sample minus slow average, then 3*fast
	logic signed [ALU_W-1:0]   acc_q;       // running floor(d*alpha / 2^16)
	logic [ppghr_pkg::BIT_W-1:0] bit_q;
	logic signed [AC_W-1:0]    ac_q;
	logic                      finger_q;
	logic                      beat_q;
	logic [SUM_W-1:0]          sum_q;
	logic [PTR_W-1:0]          idx_q;
	logic [NUM_W-1:0]          num_q;
	logic [NUM_W-1:0]          quo_q;
	logic [SUM_W-1:0]          rem_q;
	logic [ppghr_pkg::DIV_CNT_W-1:0] div_cnt_q;

	// ---------------- output register ----------------
	logic                      out_valid_q;
	logic signed [AC_W-1:0]    ac_out_q;
	logic                      finger_out_q;
	logic                      beat_out_q;
	logic [BPM_W-1:0]          bpm_out_q;

	// ---------------- shared add/subtract unit ----------------
	logic signed [ALU_W-1:0] alu_a;
	logic signed [ALU_W-1:0] alu_b;
	logic                    alu_sub;
	logic signed [ALU_W-1:0] alu_sum;

	assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);

	// helper views
	logic [AVG_W-1:0]        scaled;     // sample in Q18.16
	logic [REM_W-1:0]        rem_sh;     // partial remainder with next dividend bit
	logic signed [AC_W-1:0]  ac_c;       // fast minus slow, truncated toward zero
	logic                    ac_round;
	logic [CNT_W-1:0]        iv_c;       // samples since the last peak, minus one
	logic                    finger_c;
	logic                    beat_c;
	logic                    iv_store_c;
	logic                    sum_last;
	logic                    div_last;
	logic                    out_free;

	assign scaled   = {sample_q, FRAC_W'(0)};
	assign rem_sh   = {rem_q, num_q[NUM_W-1]};
	assign ac_round = alu_sum[ALU_W-1] && (|alu_sum[FRAC_W-1:0]);
	assign ac_c     = alu_sum[FRAC_W+AC_W-1:FRAC_W] + AC_W'(ac_round);
	assign iv_c     = alu_sum[CNT_W-1:0];
	assign sum_last = (STORED_W'(idx_q) == stored_q - STORED_W'(1));
	assign div_last = (div_cnt_q == ppghr_pkg::DIV_CNT_W'(NUM_W - 1));
	assign out_free = !out_valid_q || out_ready;

	// finger: raw level above threshold and |ac| above the floor
	assign finger_c = (sample_q > thr_q) &&
		((ac_q > AC_W'(ppghr_pkg::AC_MAG_MIN)) || (ac_q < -AC_W'(ppghr_pkg::AC_MAG_MIN)));

	// beat: middle entry a local maximum above the peak floor (a positive middle is
	// always above a third of itself), and at least min interval since the last peak
	assign beat_c = finger_c &&
		(hist_mid_q > hist_old_q) && (hist_mid_q > ac_q) &&
		(hist_mid_q > AC_W'(ppghr_pkg::PEAK_MIN)) &&
		(iv_c >= CNT_W'(min_iv_q)) && (iv_c != {CNT_W{1'b1}});

	// interval kept only after a first peak and when not above the limit
	assign iv_store_c = peak_seen_q && (iv_c <= CNT_W'(max_iv_q));

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ppghr_pkg::ST_IDLE: begin
				if (in_valid) state_d = ppghr_pkg::ST_LOAD;
			end
			ppghr_pkg::ST_LOAD:  state_d = ppghr_pkg::ST_DIFF;
			ppghr_pkg::ST_DIFF:  state_d = ppghr_pkg::ST_MUL;
			ppghr_pkg::ST_MUL: begin
				if (bit_q == ppghr_pkg::BIT_W'(FRAC_W - 1)) state_d = ppghr_pkg::ST_SLOW;
			end
			ppghr_pkg::ST_SLOW:  state_d = ppghr_pkg::ST_FAST1;
			ppghr_pkg::ST_FAST1: state_d = ppghr_pkg::ST_FAST2;
			ppghr_pkg::ST_FAST2: state_d = ppghr_pkg::ST_AC;
			ppghr_pkg::ST_AC:    state_d = ppghr_pkg::ST_DETECT;
			ppghr_pkg::ST_DETECT: begin
				state_d = beat_c ? ppghr_pkg::ST_NUM : ppghr_pkg::ST_DONE;
			end
			ppghr_pkg::ST_NUM: begin
				if (stored_q < STORED_W'(ppghr_pkg::MIN_INTERVALS))
					state_d = ppghr_pkg::ST_DONE;
				else
					state_d = ppghr_pkg::ST_SUM;
			end
			ppghr_pkg::ST_SUM: begin
				if (sum_last)
					state_d = (alu_sum == '0) ? ppghr_pkg::ST_DONE : ppghr_pkg::ST_DIV;
			end
			ppghr_pkg::ST_DIV: begin
				if (div_last) state_d = ppghr_pkg::ST_SAT;
			end
			ppghr_pkg::ST_SAT:   state_d = ppghr_pkg::ST_DONE;
			ppghr_pkg::ST_DONE: begin
				if (out_free) state_d = ppghr_pkg::ST_IDLE;
			end
			default: state_d = ppghr_pkg::ST_IDLE;
		endcase
	end

	// ---------------- operand select and handshake outputs ----------------
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		in_ready = 1'b0;
		case (state_q)
			ppghr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			ppghr_pkg::ST_DIFF: begin
				// averages already loaded when zero, so this is sample - slow
				alu_a   = $signed(ALU_W'(scaled));
				alu_b   = $signed(ALU_W'(slow_q));
				alu_sub = 1'b1;
			end
			ppghr_pkg::ST_MUL: begin
				// lsb-first shift-add, one alpha bit a step
				alu_a = acc_q;
				alu_b = alpha_q[bit_q] ? d_q : '0;
			end
			ppghr_pkg::ST_SLOW: begin
				alu_a = $signed(ALU_W'(slow_q));
				alu_b = acc_q;
			end
			ppghr_pkg::ST_FAST1: begin
				alu_a = $signed(ALU_W'({fast_q, 1'b0}));
				alu_b = $signed(ALU_W'(fast_q));
			end
			ppghr_pkg::ST_FAST2: begin
				alu_a = d_q;
				alu_b = $signed(ALU_W'(scaled));
			end
			ppghr_pkg::ST_AC: begin
				alu_a   = $signed(ALU_W'(fast_q));
				alu_b   = $signed(ALU_W'(slow_q));
				alu_sub = 1'b1;
			end
			ppghr_pkg::ST_DETECT: begin
				// modulo 2^32 distance to the last peak
				alu_a   = $signed(ALU_W'(cnt_q));
				alu_b   = $signed(ALU_W'(last_peak_q));
				alu_sub = 1'b1;
			end
			ppghr_pkg::ST_SUM: begin
				alu_a = $signed(ALU_W'(sum_q));
				alu_b = $signed(ALU_W'(ring_q[idx_q]));
			end
			ppghr_pkg::ST_DIV: begin
				alu_a   = $signed(ALU_W'(rem_sh));
				alu_b   = $signed(ALU_W'(sum_q));
				alu_sub = 1'b1;
			end
			default: begin
				alu_sub = 1'b0;
			end
		endcase
	end

	// ---------------- control and detector state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ppghr_pkg::ST_IDLE;
			rate_q      <= ppghr_pkg::RESET_SAMPLE_RATE;
			thr_q       <= ppghr_pkg::RESET_IR_THR;
			alpha_q     <= ppghr_pkg::RESET_DC_ALPHA;
			min_iv_q    <= ppghr_pkg::RESET_MIN_IV;
			max_iv_q    <= ppghr_pkg::RESET_MAX_IV;
			slow_q      <= '0;
			fast_q      <= '0;
			hist_old_q  <= '0;
			hist_mid_q  <= '0;
			cnt_q       <= '0;
			last_peak_q <= '0;
			peak_seen_q <= 1'b0;
			ptr_q       <= '0;
			stored_q    <= '0;
			bpm_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				case (cfg_index)
					ppghr_pkg::REG_SAMPLE_RATE:  rate_q   <= cfg_data[ppghr_pkg::RATE_W-1:0];
					ppghr_pkg::REG_IR_THRESHOLD: thr_q    <= cfg_data[ppghr_pkg::THR_W-1:0];
					ppghr_pkg::REG_DC_ALPHA:     alpha_q  <= cfg_data[ppghr_pkg::ALPHA_W-1:0];
					ppghr_pkg::REG_MIN_INTERVAL: min_iv_q <= cfg_data[ppghr_pkg::MIN_IV_W-1:0];
					ppghr_pkg::REG_MAX_INTERVAL: max_iv_q <= cfg_data[IV_W-1:0];
					default: ;
				endcase
			end

			case (state_q)
				ppghr_pkg::ST_LOAD: begin
					// an empty average starts at the sample itself
					if (slow_q == '0) slow_q <= scaled;
					if (fast_q == '0) fast_q <= scaled;
				end
				ppghr_pkg::ST_SLOW:  slow_q <= alu_sum[AVG_W-1:0];
				ppghr_pkg::ST_FAST2: fast_q <= alu_sum[AVG_W+1:2];
				ppghr_pkg::ST_DETECT: begin
					if (finger_c) begin
						hist_old_q <= hist_mid_q;
						hist_mid_q <= ac_q;
					end
					if (beat_c) begin
						if (iv_store_c) begin
							ptr_q <= (ptr_q == PTR_W'(SLOTS - 1)) ? '0 : ptr_q + PTR_W'(1);
							if (stored_q < STORED_W'(SLOTS))
								stored_q <= stored_q + STORED_W'(1);
						end
						peak_seen_q <= 1'b1;
						last_peak_q <= cnt_q;
					end
					cnt_q <= cnt_q + CNT_W'(1);
				end
				ppghr_pkg::ST_NUM: begin
					if (stored_q < STORED_W'(ppghr_pkg::MIN_INTERVALS)) bpm_q <= '0;
				end
				ppghr_pkg::ST_SUM: begin
					if (sum_last && alu_sum == '0) bpm_q <= '0;
				end
				ppghr_pkg::ST_SAT: begin
					// quotient above 16 bits saturates
					bpm_q <= (|quo_q[NUM_W-1:BPM_W]) ? {BPM_W{1'b1}} : quo_q[BPM_W-1:0];
				end
				default: ;
			endcase

			if (state_q == ppghr_pkg::ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// ---------------- working registers and interval ring ----------------
	always_ff @(posedge clk) begin
		case (state_q)
			ppghr_pkg::ST_IDLE: begin
				if (in_valid) sample_q <= ir_sample;
			end
			ppghr_pkg::ST_LOAD: begin
				acc_q <= '0;
				bit_q <= '0;
			end
			ppghr_pkg::ST_DIFF:  d_q <= alu_sum;
			ppghr_pkg::ST_MUL: begin
				acc_q <= alu_sum >>> 1;
				bit_q <= bit_q + ppghr_pkg::BIT_W'(1);
			end
			ppghr_pkg::ST_FAST1: d_q <= alu_sum;
			ppghr_pkg::ST_AC:    ac_q <= ac_c;
			ppghr_pkg::ST_DETECT: begin
				finger_q <= finger_c;
				beat_q   <= beat_c;
				if (beat_c && iv_store_c) ring_q[ptr_q] <= iv_c[IV_W-1:0];
			end
			ppghr_pkg::ST_NUM: begin
				num_q <= {RC_W'(RC_W'(rate_q) * RC_W'(ppghr_pkg::SECONDS_MIN) * RC_W'(stored_q)),
					ppghr_pkg::BPM_FRAC'(0)};
				sum_q <= '0;
				idx_q <= '0;
			end
			ppghr_pkg::ST_SUM: begin
				sum_q     <= alu_sum[SUM_W-1:0];
				idx_q     <= idx_q + PTR_W'(1);
				rem_q     <= '0;
				quo_q     <= '0;
				div_cnt_q <= '0;
			end
			ppghr_pkg::ST_DIV: begin
				// restoring division, one quotient bit a cycle
				if (!alu_sum[ALU_W-1]) rem_q <= alu_sum[SUM_W-1:0];
				else                   rem_q <= rem_sh[SUM_W-1:0];
				quo_q     <= {quo_q[NUM_W-2:0], !alu_sum[ALU_W-1]};
				num_q     <= {num_q[NUM_W-2:0], 1'b0};
				div_cnt_q <= div_cnt_q + ppghr_pkg::DIV_CNT_W'(1);
			end
			ppghr_pkg::ST_DONE: begin
				if (out_free) begin
					ac_out_q     <= ac_q;
					finger_out_q <= finger_q;
					beat_out_q   <= beat_q;
					bpm_out_q    <= bpm_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign ac_value       = ac_out_q;
	assign finger_present = finger_out_q;
	assign beat_found     = beat_out_q;
	assign bpm            = bpm_out_q;

`ifndef ASSERT_OFF
	// a beat is only ever reported together with a finger
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!beat_found || finger_present))
		else $error("beat reported without finger");

	// bpm stays zero until two intervals are stored
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ppghr_pkg::ST_IDLE && stored_q < STORED_W'(ppghr_pkg::MIN_INTERVALS))
		|-> (bpm_q == '0))
		else $error("bpm nonzero with too few intervals");

	// write pointer follows the fill count until the ring is full
	assert property (@(posedge clk) disable iff (!arst_n)
		(stored_q < STORED_W'(SLOTS)) |-> (STORED_W'(ptr_q) == stored_q))
		else $error("ring pointer out of step with fill count");

	// fill count never exceeds the ring depth
	assert property (@(posedge clk) disable iff (!arst_n)
		stored_q <= STORED_W'(SLOTS))
		else $error("interval count overflow");
`endif

endmodule
